[src/waypoint_motion_stepper_assert.svh]
// Assertion macros for the waypoint motion stepper.
`ifndef WAYPOINT_MOTION_STEPPER_ASSERT_SVH
`define WAYPOINT_MOTION_STEPPER_ASSERT_SVH

`ifndef SYNTHESIS

`define WMS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("invariant violated");

`define WMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication violated");

`define WMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check violated");

`else

`define WMS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define WMS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define WMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/wms_pkg.sv]
`default_nettype none

package wms_pkg;

	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_WRITE   = 2'd1;
	localparam logic [1:0] ACT_START   = 2'd2;
	localparam logic [1:0] ACT_SET_POS = 2'd3;

	localparam logic REG_STEP_LENGTH   = 1'b0;
	localparam logic REG_ARRIVE_MARGIN = 1'b1;

	localparam logic [15:0] STEP_LENGTH_RESET   = 16'd2560;
	localparam logic [15:0] ARRIVE_MARGIN_RESET = 16'd2586;

	localparam int POS_W  = 24;
	localparam int HDG_W  = 16;
	localparam int SLOT_W = 8;
	localparam int PLEN_W = 9;
	localparam int CFG_W  = 16;

	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 80;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [HDG_W-1:0] hdg_t;

	typedef struct packed {
		hdg_t a;
		pos_t y;
		pos_t x;
	} waypoint_t;

endpackage

`default_nettype wire

[src/waypoint_motion_stepper.sv]
`default_nettype none
`include "waypoint_motion_stepper_assert.svh"

// Steps a 2D Q15.8 position along a stored list of waypoints. Each request on
// the input stream writes a waypoint, starts a path, sets the position or ticks;
// each one yields exactly one result carrying the position, heading, arrived
// flag and aimed slot after the request. Write, start and set-position requests
// go straight to the result state. A tick on an active path computes the
// distance as a bit-per-cycle square root and the two axis moves as bit-per-cycle
// quotients, all through one shared compare-subtract unit, with one shared
// multiplier for the squares and scaled moves. The input is not ready while a
// request is in work.
module waypoint_motion_stepper #(
	parameter int WAYPOINT_DEPTH = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [7:0] slot, [31:8] coord_x, [55:32] coord_y, [71:56] heading,
	// [80:72] path_length, [87:81] zero
	input  wire logic [wms_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [1:0] action
	input  wire logic [wms_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [23:0] now_x, [47:24] now_y, [63:48] now_heading, [64] arrived,
	// [72:65] active_slot, [79:73] zero
	output logic [wms_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [2:0]                         paddr,
	input  wire logic [31:0]                        pwdata,
	output logic [31:0]                             prdata,
	output logic                                    pready
);

	localparam int AW  = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
	localparam int IW  = (AW > wms_pkg::SLOT_W) ? AW : wms_pkg::SLOT_W;
	localparam int CAP = (WAYPOINT_DEPTH < 256) ? WAYPOINT_DEPTH : 256;
	localparam logic [wms_pkg::PLEN_W-1:0] CAP_LEN = wms_pkg::PLEN_W'(CAP);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_SQX   = 4'd2;
	localparam logic [3:0] ST_SQY   = 4'd3;
	localparam logic [3:0] ST_SQADD = 4'd4;
	localparam logic [3:0] ST_ROOT  = 4'd5;
	localparam logic [3:0] ST_MSEL  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_DIVI  = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_STEP  = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;

	localparam logic [4:0] LAST_ITER = 5'd24;

	// input fields
	logic [1:0]                    in_action;
	logic [wms_pkg::SLOT_W-1:0]    in_slot;
	wms_pkg::pos_t                 in_x;
	wms_pkg::pos_t                 in_y;
	wms_pkg::hdg_t                 in_hdg;
	logic [wms_pkg::PLEN_W-1:0]    in_plen;

	assign in_action = s_axis_tuser[1:0];
	assign in_slot   = s_axis_tdata[7:0];
	assign in_x      = s_axis_tdata[31:8];
	assign in_y      = s_axis_tdata[55:32];
	assign in_hdg    = s_axis_tdata[71:56];
	assign in_plen   = s_axis_tdata[80:72];

	// control state
	logic [3:0]                    state_q;
	logic [4:0]                    cnt_q;
	logic                          axis_q;
	wms_pkg::pos_t                 x_q;
	wms_pkg::pos_t                 y_q;
	wms_pkg::hdg_t                 hd_q;
	logic [wms_pkg::PLEN_W-1:0]    path_q;
	logic [wms_pkg::SLOT_W-1:0]    cur_q;
	logic                          reached_q;
	logic [wms_pkg::CFG_W-1:0]     step_q;
	logic [wms_pkg::CFG_W-1:0]     margin_q;
	logic                          m_valid_q;

	// datapath
	wms_pkg::waypoint_t            mem [WAYPOINT_DEPTH];
	wms_pkg::waypoint_t            rd_q;
	wms_pkg::pos_t                 wx_q;
	wms_pkg::pos_t                 wy_q;
	wms_pkg::hdg_t                 wa_q;
	logic signed [24:0]            dx_q;
	logic signed [24:0]            dy_q;
	logic [24:0]                   magx_q;
	logic [24:0]                   magy_q;
	logic                          negx_q;
	logic                          negy_q;
	logic [49:0]                   prod_q;
	logic [49:0]                   rad_q;
	logic [27:0]                   rem_q;
	logic [24:0]                   root_q;
	logic [40:0]                   num_q;
	logic [24:0]                   quo_q;
	logic [15:0]                   m_q;
	wms_pkg::pos_t                 nx_q;
	wms_pkg::pos_t                 ny_q;
	logic [wms_pkg::OUT_DATA_W-1:0] out_q;

	logic                          accept;
	logic                          tick_go;
	logic                          wr_en;
	logic [IW-1:0]                 wr_wide;
	logic [IW-1:0]                 rd_wide;
	logic [AW-1:0]                 wr_addr;
	logic [AW-1:0]                 rd_addr;
	logic                          cfg_wr;
	logic                          emit_go;
	logic [wms_pkg::PLEN_W-1:0]    cur_next;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign tick_go       = (path_q != '0) && (32'(cur_q) < 32'(WAYPOINT_DEPTH));
	assign wr_wide       = IW'(in_slot);
	assign rd_wide       = IW'(cur_q);
	assign wr_addr       = wr_wide[AW-1:0];
	assign rd_addr       = rd_wide[AW-1:0];
	assign wr_en         = accept && (in_action == wms_pkg::ACT_WRITE) &&
	                       (32'(in_slot) < 32'(WAYPOINT_DEPTH));
	assign cfg_wr        = psel && penable && pwrite && pready;
	assign emit_go       = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);
	assign cur_next      = {1'b0, cur_q} + 9'd1;

	assign pready        = 1'b1;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_q;

	always_comb begin
		case (paddr[2])
			wms_pkg::REG_STEP_LENGTH:   prdata = {16'd0, step_q};
			wms_pkg::REG_ARRIVE_MARGIN: prdata = {16'd0, margin_q};
			default:                    prdata = '0;
		endcase
	end

	// shared multiplier
	logic signed [25:0] mul_a;
	logic signed [25:0] mul_b;
	logic signed [51:0] mul_p;

	always_comb begin
		case (state_q)
			ST_SQX: begin
				mul_a = {dx_q[24], dx_q};
				mul_b = {dx_q[24], dx_q};
			end
			ST_SQY: begin
				mul_a = {dy_q[24], dy_q};
				mul_b = {dy_q[24], dy_q};
			end
			default: begin
				mul_a = {1'b0, (axis_q ? magy_q : magx_q)};
				mul_b = {10'd0, m_q};
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// shared compare-subtract
	logic [27:0] su_a;
	logic [27:0] su_b;
	logic [28:0] su_d;
	logic        su_ge;

	always_comb begin
		case (state_q)
			ST_ROOT: begin
				su_a = {rem_q[25:0], rad_q[49:48]};
				su_b = {1'b0, root_q, 2'b01};
			end
			default: begin
				su_a = {2'b00, rem_q[24:0], num_q[24]};
				su_b = {3'b000, root_q};
			end
		endcase
	end

	assign su_d  = {1'b0, su_a} - {1'b0, su_b};
	assign su_ge = !su_d[28];

	// axis step with saturation
	wms_pkg::pos_t      step_pos;
	logic signed [25:0] step_delta;
	logic signed [25:0] step_sum;
	wms_pkg::pos_t      step_sat;

	assign step_pos   = axis_q ? y_q : x_q;
	assign step_delta = (axis_q ? negy_q : negx_q) ? -$signed({1'b0, quo_q})
	                                                :  $signed({1'b0, quo_q});
	assign step_sum   = {{2{step_pos[23]}}, step_pos} + step_delta;

	always_comb begin
		if (step_sum > 26'sd8388607) begin
			step_sat = 24'sh7FFFFF;
		end else if (step_sum < -26'sd8388608) begin
			step_sat = 24'sh800000;
		end else begin
			step_sat = step_sum[23:0];
		end
	end

	// reach test
	logic signed [24:0] ex;
	logic signed [24:0] ey;
	logic [24:0]        ex_abs;
	logic [24:0]        ey_abs;
	logic               reach;

	assign ex     = {wx_q[23], wx_q} - {nx_q[23], nx_q};
	assign ey     = {wy_q[23], wy_q} - {ny_q[23], ny_q};
	assign ex_abs = ex[24] ? 25'(-ex) : 25'(ex);
	assign ey_abs = ey[24] ? 25'(-ey) : 25'(ey);
	assign reach  = (ex_abs < {9'd0, margin_q}) && (ey_abs < {9'd0, margin_q});

	logic [40:0] div_num;
	assign div_num = prod_q[40:0] + {17'd0, root_q[24:1]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{a: in_hdg, y: in_y, x: in_x};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			axis_q    <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			hd_q      <= '0;
			path_q    <= '0;
			cur_q     <= '0;
			reached_q <= 1'b0;
			step_q    <= wms_pkg::STEP_LENGTH_RESET;
			margin_q  <= wms_pkg::ARRIVE_MARGIN_RESET;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					wms_pkg::REG_STEP_LENGTH:   step_q   <= pwdata[15:0];
					wms_pkg::REG_ARRIVE_MARGIN: margin_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (emit_go) begin
				m_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EMIT;
						case (in_action)
							wms_pkg::ACT_TICK: begin
								if (tick_go) begin
									state_q <= ST_LOAD;
								end
							end
							wms_pkg::ACT_START: begin
								path_q    <= (in_plen > CAP_LEN) ? CAP_LEN : in_plen;
								cur_q     <= '0;
								reached_q <= 1'b0;
							end
							wms_pkg::ACT_SET_POS: begin
								x_q  <= in_x;
								y_q  <= in_y;
								hd_q <= in_hdg;
							end
							default: ;
						endcase
					end
				end
				ST_LOAD:  state_q <= ST_SQX;
				ST_SQX:   state_q <= ST_SQY;
				ST_SQY:   state_q <= ST_SQADD;
				ST_SQADD: begin
					cnt_q   <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_ITER) begin
						state_q <= ST_MSEL;
					end
				end
				ST_MSEL: begin
					axis_q  <= 1'b0;
					state_q <= (root_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_MUL:   state_q <= ST_DIVI;
				ST_DIVI: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_ITER) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					x_q  <= nx_q;
					y_q  <= ny_q;
					hd_q <= wa_q;
					if (reach) begin
						if (cur_next == path_q) begin
							reached_q <= 1'b1;
						end else begin
							cur_q <= cur_next[7:0];
						end
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p[49:0];
		case (state_q)
			ST_LOAD: begin
				wx_q <= rd_q.x;
				wy_q <= rd_q.y;
				wa_q <= rd_q.a;
				dx_q <= {rd_q.x[23], rd_q.x} - {x_q[23], x_q};
				dy_q <= {rd_q.y[23], rd_q.y} - {y_q[23], y_q};
			end
			ST_SQY: begin
				rad_q  <= prod_q;
				magx_q <= dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
				magy_q <= dy_q[24] ? 25'(-dy_q) : 25'(dy_q);
				negx_q <= dx_q[24];
				negy_q <= dy_q[24];
			end
			ST_SQADD: begin
				rad_q  <= rad_q + prod_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				rem_q  <= su_ge ? su_d[27:0] : su_a;
				root_q <= {root_q[23:0], su_ge};
				rad_q  <= {rad_q[47:0], 2'b00};
			end
			ST_MSEL: begin
				nx_q <= x_q;
				ny_q <= y_q;
				m_q  <= (root_q > {9'd0, step_q}) ? step_q : root_q[15:0];
			end
			ST_DIVI: begin
				num_q <= div_num;
				rem_q <= {12'd0, div_num[40:25]};
			end
			ST_DIV: begin
				rem_q <= su_ge ? su_d[27:0] : su_a;
				num_q <= {num_q[39:0], 1'b0};
				quo_q <= {quo_q[23:0], su_ge};
			end
			ST_STEP: begin
				if (axis_q) begin
					ny_q <= step_sat;
				end else begin
					nx_q <= step_sat;
				end
			end
			default: ;
		endcase
		if (emit_go) begin
			out_q <= {7'd0, cur_q, reached_q, hd_q, y_q, x_q};
		end
	end

	`WMS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_axis_tready)
	`WMS_ASSERT_IMPL(a_iter_bound, clk, arst_n,
		(state_q == ST_ROOT) || (state_q == ST_DIV), cnt_q <= LAST_ITER)
	`WMS_ASSERT_ALWAYS(a_slot_in_path, clk, arst_n,
		(path_q == '0) || ({1'b0, cur_q} < path_q))
	`WMS_ASSERT_IMPL(a_reached_on_last, clk, arst_n, reached_q, cur_next == path_q)

endmodule

`default_nettype wire
